// ===== hw/rtl/ttip_pkg.sv =====
`default_nettype none

package ttip_pkg;

    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
    localparam int unsigned CH_W     = 16;
    localparam int unsigned VAL_W    = 64;
    localparam int unsigned IDX_W    = 1;

    localparam logic [IDX_W-1:0] REG_SIGNED_MODE   = 1'b0;
    localparam logic [IDX_W-1:0] REG_DEFAULT_VALUE = 1'b1;

    localparam logic [CH_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CH_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CH_W-1:0] CH_LO_A  = 16'h0061;
    localparam logic [CH_W-1:0] CH_LO_F  = 16'h0066;
    localparam logic [CH_W-1:0] CH_UP_A  = 16'h0041;
    localparam logic [CH_W-1:0] CH_UP_F  = 16'h0046;
    localparam logic [CH_W-1:0] CH_X     = 16'h0078;
    localparam logic [CH_W-1:0] CH_MINUS = 16'h002d;

    localparam logic [1:0] COUNT_MAX = 2'd3;

    typedef struct packed {
        logic       char_valid;
        logic       last;
        logic       is_dec;
        logic       is_hex;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic [3:0] digit;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttip_front.sv =====
`default_nettype none

module ttip_front
    import ttip_pkg::*;
(
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [CH_W-1:0] ch,
    input  wire logic            char_valid,
    input  wire logic            last,
    input  wire q_status_t       q_status,
    output logic                 push,
    output entry_t               push_data
);

    logic is_lo;
    logic is_up;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    assign is_lo = (ch >= CH_LO_A) && (ch <= CH_LO_F);
    assign is_up = (ch >= CH_UP_A) && (ch <= CH_UP_F);

    always_comb
    begin
        push_data.char_valid = char_valid;
        push_data.last       = last;
        push_data.is_dec     = (ch >= CH_ZERO) && (ch <= CH_NINE);
        push_data.is_hex     = push_data.is_dec || is_lo || is_up;
        push_data.is_minus   = (ch == CH_MINUS);
        push_data.is_zero    = (ch == CH_ZERO);
        push_data.is_x       = (ch == CH_X);
        if (push_data.is_dec)
        begin
            push_data.digit = ch[3:0];
        end
        else
        begin
            push_data.digit = ch[3:0] + 4'd9;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ttip_queue.sv =====
`default_nettype none

module ttip_queue
    import ttip_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    input  wire logic   pop,
    output entry_t      pop_data,
    output q_status_t   q_status
);

    entry_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign q_status.full      = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign pop_data           = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ttip_back.sv =====
`default_nettype none

module ttip_back
    import ttip_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire entry_t           q_data,
    output logic                  q_pop,
    input  wire logic             signed_mode,
    input  wire logic [VAL_W-1:0] default_value,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [VAL_W-1:0]      value,
    output logic                  used_default,
    output logic                  hex_form
);

    logic [1:0]       count_reg;
    logic [VAL_W-1:0] acc_reg;
    logic             stopped_reg;
    logic             hex_reg;
    logic             neg_reg;
    logic             seen_reg;
    logic             zx_reg;

    logic [1:0]       count_next;
    logic [VAL_W-1:0] acc_next;
    logic             stopped_next;
    logic             hex_next;
    logic             neg_next;
    logic             seen_next;
    logic             zx_next;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_acc_reg;
    logic             out_neg_reg;
    logic             out_def_reg;
    logic             out_hex_reg;

    logic             out_free;
    logic [VAL_W-1:0] acc_dec;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = q_valid && (!q_data.last || out_free);

    always_comb
    begin
        count_next   = count_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        hex_next     = hex_reg;
        neg_next     = neg_reg;
        seen_next    = seen_reg;
        zx_next      = zx_reg;

        if (q_data.char_valid)
        begin
            if (count_reg == 2'd0)
            begin
                zx_next = q_data.is_zero;
            end
            else if (count_reg == 2'd1)
            begin
                zx_next = zx_reg && q_data.is_x;
            end
            else if (count_reg == 2'd2 && zx_reg)
            begin
                hex_next     = 1'b1;
                acc_next     = '0;
                stopped_next = 1'b0;
                seen_next    = 1'b0;
                neg_next     = 1'b0;
            end

            if (!stopped_next)
            begin
                if (hex_next)
                begin
                    if (q_data.is_hex)
                    begin
                        acc_next  = {acc_next[VAL_W-5:0], q_data.digit};
                        seen_next = 1'b1;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                else if (count_reg == 2'd0 && signed_mode && q_data.is_minus)
                begin
                    neg_next = 1'b1;
                end
                else if (q_data.is_dec)
                begin
                    acc_next  = acc_dec;
                    seen_next = 1'b1;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end

            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 2'd1;
            end
        end
    end

    assign acc_dec = {acc_reg[VAL_W-4:0], 3'b000} + {acc_reg[VAL_W-2:0], 1'b0}
                     + {{(VAL_W-4){1'b0}}, q_data.digit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            acc_reg       <= '0;
            stopped_reg   <= 1'b0;
            hex_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            zx_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_data.last)
                begin
                    count_reg   <= '0;
                    acc_reg     <= '0;
                    stopped_reg <= 1'b0;
                    hex_reg     <= 1'b0;
                    neg_reg     <= 1'b0;
                    seen_reg    <= 1'b0;
                    zx_reg      <= 1'b0;
                end
                else
                begin
                    count_reg   <= count_next;
                    acc_reg     <= acc_next;
                    stopped_reg <= stopped_next;
                    hex_reg     <= hex_next;
                    neg_reg     <= neg_next;
                    seen_reg    <= seen_next;
                    zx_reg      <= zx_next;
                end
            end

            if (q_pop && q_data.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.last)
        begin
            if (hex_next)
            begin
                out_acc_reg <= acc_next;
                out_neg_reg <= 1'b0;
                out_def_reg <= 1'b0;
                out_hex_reg <= 1'b1;
            end
            else if (seen_next)
            begin
                out_acc_reg <= acc_next;
                out_neg_reg <= neg_next;
                out_def_reg <= 1'b0;
                out_hex_reg <= 1'b0;
            end
            else
            begin
                out_acc_reg <= default_value;
                out_neg_reg <= 1'b0;
                out_def_reg <= 1'b1;
                out_hex_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = out_neg_reg ? (VAL_W'(0) - out_acc_reg) : out_acc_reg;
    assign used_default = out_def_reg;
    assign hex_form     = out_hex_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/text_to_integer_parser_unit.sv =====
// out_valid is registered and is set by the pop of the word marked last.
// Throughput: one input word per cycle while in_stall is low; the four-entry queue
// and the output register let input and output stall independently.
// The accumulator step (x10 plus digit; nibble shift for hex) is combinational.
// Reset: asynchronous, active low; clears parse state, queue, output valid,
// and both configuration registers to zero.
`default_nettype none

module text_to_integer_parser_unit
    import ttip_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [VAL_W-1:0]  wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CH_W-1:0]   ch,
    input  wire logic              char_valid,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [VAL_W-1:0]       value,
    output logic                   used_default,
    output logic                   hex_form
);

    logic             signed_mode_reg;
    logic [VAL_W-1:0] default_value_reg;

    q_status_t q_status;
    logic      push;
    entry_t    push_data;
    logic      pop;
    entry_t    pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg   <= 1'b0;
            default_value_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SIGNED_MODE:   signed_mode_reg   <= wr_data[0];
                REG_DEFAULT_VALUE: default_value_reg <= wr_data;
                default:           ;
            endcase
        end
    end

    ttip_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .char_valid (char_valid),
        .last       (last),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    ttip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    ttip_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_status.not_empty),
        .q_data        (pop_data),
        .q_pop         (pop),
        .signed_mode   (signed_mode_reg),
        .default_value (default_value_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .used_default  (used_default),
        .hex_form      (hex_form)
    );

endmodule

`default_nettype wire

// ===== verif/text_to_integer_parser_unit_tb.sv =====
`default_nettype none

module text_to_integer_parser_unit_tb;
    import ttip_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             used_default;
        logic             hex_form;
    } parse_result_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  c;
        logic             cv;
        logic             lst;
        logic             chk;
        logic [VAL_W-1:0] v;
        logic             dflt;
        logic             hx;
    } row_t;

    localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
    localparam logic [CH_W-1:0]  CH_UP_X  = 16'h0058;
    localparam logic [4:0]       NOT_HEX  = 5'h10;
    localparam int               NUM_ROWS = 29;
    localparam int               NUM_PHASES = 8;

    localparam row_t ROWS [0:NUM_ROWS-1] = '{
        '{ROW_WORD, 1'b0, 16'h0000,      1'b0, 1'b1, 1'b1, 64'd0,    1'b1, 1'b0},
        '{ROW_CFG,  REG_SIGNED_MODE,   16'h0000, 1'b0, 1'b0, 1'b0, 64'd1,    1'b0, 1'b0},
        '{ROW_CFG,  REG_DEFAULT_VALUE, 16'h0000, 1'b0, 1'b0, 1'b0, ALL_ONES, 1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_MINUS,      1'b1, 1'b1, 1'b1, ALL_ONES, 1'b1, 1'b0},
        '{ROW_WORD, 1'b0, CH_MINUS,      1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO + 16'd5, 1'b1, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFB,
          1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO,       1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_X,          1'b1, 1'b1, 1'b1, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO,       1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_X,          1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_UP_F,       1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_LO_F,       1'b1, 1'b1, 1'b1, 64'd255,  1'b0, 1'b1},
        '{ROW_WORD, 1'b0, CH_ZERO,       1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_X,          1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_LO_F + 16'd1, 1'b1, 1'b1, 1'b1, 64'd0,  1'b0, 1'b1},
        '{ROW_WORD, 1'b0, CH_MINUS,      1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_MINUS,      1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO + 16'd1, 1'b1, 1'b1, 1'b1, ALL_ONES, 1'b1, 1'b0},
        '{ROW_WORD, 1'b0, 16'hFFFF,      1'b1, 1'b1, 1'b1, ALL_ONES, 1'b1, 1'b0},
        '{ROW_WORD, 1'b0, 16'h0131,      1'b0, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO + 16'd7, 1'b1, 1'b1, 1'b0, 64'd0,  1'b0, 1'b0},
        '{ROW_CFG,  REG_SIGNED_MODE,   16'h0000, 1'b0, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_DEFAULT_VALUE, 16'h0000, 1'b0, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_MINUS,      1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO + 16'd3, 1'b1, 1'b1, 1'b1, 64'd0,  1'b1, 1'b0},
        '{ROW_WORD, 1'b0, CH_ZERO,       1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_UP_X,       1'b1, 1'b0, 1'b0, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, CH_UP_A,       1'b1, 1'b1, 1'b1, 64'd0,    1'b0, 1'b0},
        '{ROW_WORD, 1'b0, 16'h0139,      1'b1, 1'b1, 1'b1, 64'd0,    1'b1, 1'b0}
    };

    logic             clk;
    logic             rst_n;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [VAL_W-1:0] wr_data;
    logic             in_valid;
    logic             in_stall;
    logic [CH_W-1:0]  ch;
    logic             char_valid;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic [VAL_W-1:0] value;
    logic             used_default;
    logic             hex_form;

    // parser copy kept alongside the block
    logic [1:0]       chars_taken;
    logic [VAL_W-1:0] number_acc;
    logic             scan_done;
    logic             in_hex;
    logic             minus_seen;
    logic             any_digit;
    logic             zero_x;
    logic             mode_signed;
    logic [VAL_W-1:0] fallback_value;

    parse_result_t    pending_results[$];
    parse_result_t    oldest_result;
    int               mismatch_count;
    int               words_sent;
    int               send_idle_pct;
    int               stall_pct;

    text_to_integer_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .char_valid   (char_valid),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .used_default (used_default),
        .hex_form     (hex_form)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [4:0] hex_nibble(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] off;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            off = c - CH_ZERO;
            return {1'b0, off[3:0]};
        end
        if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            off = c - CH_LO_A + 16'd10;
            return {1'b0, off[3:0]};
        end
        if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            off = c - CH_UP_A + 16'd10;
            return {1'b0, off[3:0]};
        end
        return NOT_HEX;
    endfunction

    task automatic clear_parser();
        chars_taken = 2'd0;
        number_acc  = '0;
        scan_done   = 1'b0;
        in_hex      = 1'b0;
        minus_seen  = 1'b0;
        any_digit   = 1'b0;
        zero_x      = 1'b0;
    endtask

    task automatic parse_word(input logic [CH_W-1:0] c, input logic cv, input logic lst);
        logic [1:0]      n;
        logic [4:0]      nib;
        logic [CH_W-1:0] dec;
        parse_result_t   res;
        if (cv)
        begin
            n = chars_taken;
            if (n == 2'd0)
                zero_x = (c == CH_ZERO);
            else if (n == 2'd1)
                zero_x = zero_x && (c == CH_X);
            else if (n == 2'd2 && zero_x)
            begin
                in_hex     = 1'b1;
                number_acc = '0;
                scan_done  = 1'b0;
                any_digit  = 1'b0;
                minus_seen = 1'b0;
            end
            if (!scan_done)
            begin
                if (in_hex)
                begin
                    nib = hex_nibble(c);
                    if (nib == NOT_HEX)
                        scan_done = 1'b1;
                    else
                    begin
                        number_acc = {number_acc[VAL_W-5:0], nib[3:0]};
                        any_digit  = 1'b1;
                    end
                end
                else if (n == 2'd0 && mode_signed && c == CH_MINUS)
                    minus_seen = 1'b1;
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    dec        = c - CH_ZERO;
                    number_acc = number_acc * 64'd10 + {48'd0, dec};
                    any_digit  = 1'b1;
                end
                else
                    scan_done = 1'b1;
            end
            if (chars_taken < COUNT_MAX)
                chars_taken = chars_taken + 2'd1;
        end
        if (lst)
        begin
            if (in_hex)
                res = '{number_acc, 1'b0, 1'b1};
            else if (any_digit)
                res = '{minus_seen ? 64'd0 - number_acc : number_acc, 1'b0, 1'b0};
            else
                res = '{fallback_value, 1'b1, 1'b0};
            pending_results = {pending_results, res};
            clear_parser();
        end
    endtask

    task automatic push_word(input logic [CH_W-1:0] c, input logic cv, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        ch         <= c;
        char_valid <= cv;
        last       <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_word(c, cv, lst);
        if (cv || lst)
            words_sent++;
    endtask

    // drop valid and wait out every pending word
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        settle();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_SIGNED_MODE)
            mode_signed = data[0];
        else
            fallback_value = data;
    endtask

    function automatic logic [CH_W-1:0] junk_char();
        case ($urandom_range(7))
            0: return CH_W'($urandom_range(16'hFFFF, 16'h0100));
            1: return CH_W'($urandom_range(255));
            2: return CH_ZERO - 16'd1;
            3: return CH_NINE + 16'd1;
            4: return CH_LO_F + 16'd1;
            5: return CH_UP_F + 16'd1;
            6: return CH_ZERO + 16'h0100 + CH_W'($urandom_range(9));
            default: return CH_MINUS;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] hex_char();
        case ($urandom_range(2))
            0: return CH_ZERO + CH_W'($urandom_range(9));
            1: return CH_LO_A + CH_W'($urandom_range(5));
            default: return CH_UP_A + CH_W'($urandom_range(5));
        endcase
    endfunction

    task automatic send_string();
        logic [CH_W-1:0] text[$];
        int              kind;
        int              len;
        int              i;
        logic            split_end;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            if ($urandom_range(99) < 40)
                text = {text, CH_MINUS};
            len = ($urandom_range(9) == 0) ? $urandom_range(22, 15) : $urandom_range(6, 1);
            for (i = 0; i < len; i++)
                text = {text, CH_ZERO + CH_W'($urandom_range(9))};
        end
        else if (kind < 70)
        begin
            text = {text, CH_ZERO};
            text = {text, CH_X};
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 14) : $urandom_range(4);
            for (i = 0; i < len; i++)
                text = {text, hex_char()};
        end
        else if (kind < 85)
        begin
            len = $urandom_range(4);
            for (i = 0; i < len; i++)
                case ($urandom_range(4))
                    0: text = {text, CH_ZERO};
                    1: text = {text, CH_X};
                    2: text = {text, CH_MINUS};
                    3: text = {text, CH_ZERO + CH_W'($urandom_range(9))};
                    default: text = {text, junk_char()};
                endcase
        end
        else
        begin
            len = $urandom_range(6);
            for (i = 0; i < len; i++)
                text = {text, CH_W'($urandom_range(16'hFFFF))};
        end
        if (kind < 70 && $urandom_range(99) < 30)
        begin
            len = $urandom_range(3, 1);
            for (i = 0; i < len; i++)
                text = {text, ($urandom_range(1) != 0) ? junk_char() : hex_char()};
        end
        split_end = (text.size() == 0) || ($urandom_range(4) == 0);
        for (i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(19) == 0)
                push_word(CH_W'($urandom_range(16'hFFFF)), 1'b0, 1'b0);
            push_word(text[i], 1'b1, !split_end && (i == text.size() - 1));
        end
        if (split_end)
            push_word(CH_W'($urandom_range(16'hFFFF)), 1'b0, 1'b1);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: value %h", value);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (value !== oldest_result.value)
                begin
                    $error("value: expected %h, got %h", oldest_result.value, value);
                    mismatch_count++;
                end
                if (used_default !== oldest_result.used_default)
                begin
                    $error("used_default: expected %b, got %b",
                           oldest_result.used_default, used_default);
                    mismatch_count++;
                end
                if (hex_form !== oldest_result.hex_form)
                begin
                    $error("hex_form: expected %b, got %b", oldest_result.hex_form, hex_form);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("text_to_integer_parser_unit verification failed");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        wr_en          <= 1'b0;
        wr_index       <= '0;
        wr_data        <= '0;
        in_valid       <= 1'b0;
        ch             <= '0;
        char_valid     <= 1'b0;
        last           <= 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        mode_signed    = 1'b0;
        fallback_value = '0;
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (ROWS[r].kind == ROW_CFG)
                write_reg(ROWS[r].idx, ROWS[r].v);
            else
            begin
                push_word(ROWS[r].c, ROWS[r].cv, ROWS[r].lst);
                if (ROWS[r].chk)
                    pending_results[pending_results.size() - 1] =
                        '{ROWS[r].v, ROWS[r].dflt, ROWS[r].hx};
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_SIGNED_MODE, 64'd0);
                    write_reg(REG_DEFAULT_VALUE, 64'd0);
                end
                1:
                begin
                    write_reg(REG_SIGNED_MODE, 64'd1);
                    write_reg(REG_DEFAULT_VALUE, ALL_ONES);
                end
                default:
                begin
                    write_reg(REG_SIGNED_MODE, {63'd0, 1'($urandom_range(1))});
                    write_reg(REG_DEFAULT_VALUE, {$urandom(), $urandom()});
                end
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 85;
                end
                default:
                begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            while (words_sent < 24 + (phase + 1) * 135)
                send_string();
        end

        settle();
        if (mismatch_count == 0)
            $display("text_to_integer_parser_unit verification clean");
        else
            $display("text_to_integer_parser_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
